// File: sv/assert_macros.svh
// Assertion macros for the RTL files; the top level includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/imu_hdr_pkg.sv
// Shared types, command codes and constant tables for the heading dead reckoning block
package imu_hdr_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_STEPS_MAX = 24;
    localparam int IDX_W            = 5;

    typedef logic [3:0] t_op;

    localparam t_op OP_NOP  = 4'd0;
    localparam t_op OP_LOAD = 4'd1;
    localparam t_op OP_QMAC = 4'd2;
    localparam t_op OP_NMAC = 4'd3;
    localparam t_op OP_VPRE = 4'd4;
    localparam t_op OP_VIT  = 4'd5;
    localparam t_op OP_VK   = 4'd6;
    localparam t_op OP_RPRE = 4'd7;
    localparam t_op OP_RIT  = 4'd8;
    localparam t_op OP_PX   = 4'd9;
    localparam t_op OP_PXA  = 4'd10;
    localparam t_op OP_PY   = 4'd11;
    localparam t_op OP_PYA  = 4'd12;
    localparam t_op OP_OUT  = 4'd13;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    // Kinv = 0.6072529350 in Q30
    localparam logic signed [30:0] KINV_Q30 = 31'sd652032874;
    localparam logic signed [33:0] HALF_PI  = 34'sd1073741824;

    // Arctangent of 2^-i in units of pi/2^31
    function automatic logic [29:0] atan_lut(input logic [IDX_W-1:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Sign of term j of relative component c (1 = subtract)
    function automatic logic q_term_neg(input logic [1:0] c, input logic [1:0] j);
        logic n;
        case (c)
            2'd0:    n = 1'b0;
            2'd1:    n = (j == 2'd0) || (j == 2'd2);
            2'd2:    n = (j == 2'd0) || (j == 2'd3);
            default: n = (j == 2'd0) || (j == 2'd1);
        endcase
        return n;
    endfunction

endpackage

// File: sv/imu_heading_dead_reckoning.sv
// Top level of the heading dead reckoning block: sequencer plus datapath
//
//  channel | direction | signals                              | accepted when
//  input   | in        | i_valid, o_stall, speed/orient/time  | i_valid && !o_stall
//  result  | out       | o_valid, i_stall, pos/heading/rel    | o_valid && !i_stall
//
// An item steps through load, quaternion product, norm terms, heading CORDIC, speed scaling,
// rotation CORDIC and position update, with N = min(CORDIC_STEPS, 24) iterations per CORDIC;
// one shared multiplier and one CORDIC stage do all of this work, one step at a time.
// The input stalls while an item is in work; a finished result waits in the output
// register, so the next item is taken while the last result is still unclaimed.
// Reset is synchronous and restores the identity reference and a zero position.
module imu_heading_dead_reckoning #(
    parameter int CORDIC_STEPS = imu_hdr_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_wheel_speed,
    input  logic signed [15:0] i_orient_w,
    input  logic signed [15:0] i_orient_x,
    input  logic signed [15:0] i_orient_y,
    input  logic signed [15:0] i_orient_z,
    input  logic        [17:0] i_time_step,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [39:0] o_pos_x,
    output logic signed [39:0] o_pos_y,
    output logic signed [15:0] o_heading,
    output logic signed [15:0] o_rel_w,
    output logic signed [15:0] o_rel_x,
    output logic signed [15:0] o_rel_y,
    output logic signed [15:0] o_rel_z
);

`include "assert_macros.svh"

    imu_hdr_pkg::t_cmd cmd;

    imu_hdr_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    imu_hdr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_wheel_speed (i_wheel_speed),
        .i_orient_w    (i_orient_w),
        .i_orient_x    (i_orient_x),
        .i_orient_y    (i_orient_y),
        .i_orient_z    (i_orient_z),
        .i_time_step   (i_time_step),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_heading     (o_heading),
        .o_rel_w       (o_rel_w),
        .o_rel_x       (o_rel_x),
        .o_rel_y       (o_rel_y),
        .o_rel_z       (o_rel_z)
    );

    // An accepted item keeps the input stalled while it is worked on
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // A result is published only from a busy sequencer
    `ASSERT_SAME(a_out_while_busy, i_clk, i_rst_n, cmd.op == imu_hdr_pkg::OP_OUT, o_stall)
    // Publishing always leaves a valid result behind
    `ASSERT_NEXT(a_out_sets_valid, i_clk, i_rst_n, cmd.op == imu_hdr_pkg::OP_OUT, o_valid)

endmodule

// File: sv/imu_hdr_ctrl.sv
// Sequencer that steps the datapath through one item and owns both handshakes
module imu_hdr_ctrl #(
    parameter int CORDIC_STEPS = imu_hdr_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output imu_hdr_pkg::t_cmd  o_cmd
);

    localparam int STEPS = (CORDIC_STEPS > imu_hdr_pkg::CORDIC_STEPS_MAX) ?
                           imu_hdr_pkg::CORDIC_STEPS_MAX : CORDIC_STEPS;
    localparam logic [imu_hdr_pkg::IDX_W-1:0] LAST_IT = imu_hdr_pkg::IDX_W'(STEPS - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_QUAT = 4'd1;
    localparam logic [3:0] S_NORM = 4'd2;
    localparam logic [3:0] S_VPRE = 4'd3;
    localparam logic [3:0] S_VIT  = 4'd4;
    localparam logic [3:0] S_VK   = 4'd5;
    localparam logic [3:0] S_RPRE = 4'd6;
    localparam logic [3:0] S_RIT  = 4'd7;
    localparam logic [3:0] S_PX   = 4'd8;
    localparam logic [3:0] S_PXA  = 4'd9;
    localparam logic [3:0] S_PY   = 4'd10;
    localparam logic [3:0] S_PYA  = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0]                   r_state, n_state;
    logic [imu_hdr_pkg::IDX_W-1:0] r_cnt, n_cnt;
    logic                         r_out_valid, n_out_valid;

    // Advance the sequence and pick the command
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        o_cmd.op    = imu_hdr_pkg::OP_NOP;
        o_cmd.idx   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = imu_hdr_pkg::OP_LOAD;
                    n_state  = S_QUAT;
                    n_cnt    = '0;
                end
            end
            S_QUAT: begin
                o_cmd.op = imu_hdr_pkg::OP_QMAC;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == 5'd15) begin
                    n_state = S_NORM;
                    n_cnt   = '0;
                end
            end
            S_NORM: begin
                o_cmd.op = imu_hdr_pkg::OP_NMAC;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == 5'd5) begin
                    n_state = S_VPRE;
                end
            end
            S_VPRE: begin
                o_cmd.op = imu_hdr_pkg::OP_VPRE;
                n_state  = S_VIT;
                n_cnt    = '0;
            end
            S_VIT: begin
                o_cmd.op = imu_hdr_pkg::OP_VIT;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == LAST_IT) begin
                    n_state = S_VK;
                end
            end
            S_VK: begin
                o_cmd.op = imu_hdr_pkg::OP_VK;
                n_state  = S_RPRE;
            end
            S_RPRE: begin
                o_cmd.op = imu_hdr_pkg::OP_RPRE;
                n_state  = S_RIT;
                n_cnt    = '0;
            end
            S_RIT: begin
                o_cmd.op = imu_hdr_pkg::OP_RIT;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == LAST_IT) begin
                    n_state = S_PX;
                end
            end
            S_PX: begin
                o_cmd.op = imu_hdr_pkg::OP_PX;
                n_state  = S_PXA;
            end
            S_PXA: begin
                o_cmd.op = imu_hdr_pkg::OP_PXA;
                n_state  = S_PY;
            end
            S_PY: begin
                o_cmd.op = imu_hdr_pkg::OP_PY;
                n_state  = S_PYA;
            end
            S_PYA: begin
                o_cmd.op = imu_hdr_pkg::OP_PYA;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register is free or being emptied
                if (!r_out_valid || !i_stall) begin
                    o_cmd.op    = imu_hdr_pkg::OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// File: sv/imu_hdr_dp.sv
// Datapath: shared multiplier, quaternion and CORDIC registers, position and output registers
module imu_hdr_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  imu_hdr_pkg::t_cmd   i_cmd,
    input  logic signed [15:0]  i_wheel_speed,
    input  logic signed [15:0]  i_orient_w,
    input  logic signed [15:0]  i_orient_x,
    input  logic signed [15:0]  i_orient_y,
    input  logic signed [15:0]  i_orient_z,
    input  logic        [17:0]  i_time_step,
    output logic signed [39:0]  o_pos_x,
    output logic signed [39:0]  o_pos_y,
    output logic signed [15:0]  o_heading,
    output logic signed [15:0]  o_rel_w,
    output logic signed [15:0]  o_rel_x,
    output logic signed [15:0]  o_rel_y,
    output logic signed [15:0]  o_rel_z
);

    logic signed [15:0] r_v;
    logic signed [15:0] r_q1 [4];
    logic signed [15:0] r_q2 [4];
    logic               r_taken;
    logic        [17:0] r_dt;
    logic signed [15:0] r_rel [4];
    logic signed [35:0] r_acc;
    logic signed [35:0] r_den;
    logic signed [35:0] r_num;
    logic signed [35:0] r_cx;
    logic signed [35:0] r_cy;
    logic signed [33:0] r_cz;
    logic               r_zero;
    logic signed [15:0] r_hd;
    logic signed [35:0] r_vk;
    logic signed [40:0] r_inc;
    logic signed [39:0] r_pos_x;
    logic signed [39:0] r_pos_y;
    logic signed [39:0] r_o_pos_x;
    logic signed [39:0] r_o_pos_y;
    logic signed [15:0] r_o_hd;
    logic signed [15:0] r_o_rel [4];

    logic [1:0]         q_c;
    logic [1:0]         q_j;
    logic signed [33:0] mul_a;
    logic signed [30:0] mul_b;
    logic signed [64:0] prod;
    logic signed [35:0] p36;
    logic               mac_neg;
    logic signed [35:0] acc_base;
    logic signed [35:0] acc_n;
    logic signed [35:0] xs;
    logic signed [35:0] ys;
    logic signed [33:0] atan_v;
    logic signed [64:0] vk_t;
    logic signed [64:0] inc_t;
    logic signed [33:0] hd_t;
    logic signed [33:0] zr;
    logic signed [41:0] pos_sum;
    logic signed [39:0] pos_sat;

    // Round half up from Q2.28 to Q1.14 and clamp to 16 bits
    function automatic logic signed [15:0] rnd_sat16(input logic signed [35:0] s);
        logic signed [35:0] t;
        t = (s + 36'sd8192) >>> 14;
        if (t > 36'sd32767) begin
            return 16'sh7FFF;
        end else if (t < -36'sd32768) begin
            return 16'sh8000;
        end
        return t[15:0];
    endfunction

    assign q_c = i_cmd.idx[3:2];
    assign q_j = i_cmd.idx[1:0];

    // Select multiplier operands for the current command
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mac_neg = 1'b0;
        case (i_cmd.op)
            imu_hdr_pkg::OP_QMAC: begin
                mul_a   = 34'(r_q1[q_j]);
                mul_b   = 31'(r_q2[q_j ^ q_c]);
                mac_neg = imu_hdr_pkg::q_term_neg(q_c, q_j);
            end
            imu_hdr_pkg::OP_NMAC: begin
                case (i_cmd.idx[2:0])
                    3'd0: begin
                        mul_a = 34'(r_rel[0]);
                        mul_b = 31'(r_rel[0]);
                    end
                    3'd1: begin
                        mul_a = 34'(r_rel[1]);
                        mul_b = 31'(r_rel[1]);
                    end
                    3'd2: begin
                        mul_a   = 34'(r_rel[2]);
                        mul_b   = 31'(r_rel[2]);
                        mac_neg = 1'b1;
                    end
                    3'd3: begin
                        mul_a   = 34'(r_rel[3]);
                        mul_b   = 31'(r_rel[3]);
                        mac_neg = 1'b1;
                    end
                    3'd4: begin
                        mul_a = 34'(r_rel[0]);
                        mul_b = 31'(r_rel[3]);
                    end
                    default: begin
                        mul_a = 34'(r_rel[1]);
                        mul_b = 31'(r_rel[2]);
                    end
                endcase
            end
            imu_hdr_pkg::OP_VK: begin
                mul_a = 34'(r_v);
                mul_b = imu_hdr_pkg::KINV_Q30;
            end
            imu_hdr_pkg::OP_PX: begin
                mul_a = r_cx[33:0];
                mul_b = $signed({13'd0, r_dt});
            end
            imu_hdr_pkg::OP_PY: begin
                mul_a = r_cy[33:0];
                mul_b = $signed({13'd0, r_dt});
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    assign prod = 65'(mul_a) * 65'(mul_b);
    assign p36  = prod[35:0];

    // Accumulate products, restarting at each group of terms
    always_comb begin
        acc_base = r_acc;
        if (i_cmd.op == imu_hdr_pkg::OP_QMAC && q_j == 2'd0) begin
            acc_base = '0;
        end
        if (i_cmd.op == imu_hdr_pkg::OP_NMAC &&
            (i_cmd.idx[2:0] == 3'd0 || i_cmd.idx[2:0] == 3'd4)) begin
            acc_base = '0;
        end
        acc_n = mac_neg ? (acc_base - p36) : (acc_base + p36);
    end

    // CORDIC shifted terms and angle step
    assign xs     = r_cx >>> i_cmd.idx;
    assign ys     = r_cy >>> i_cmd.idx;
    assign atan_v = $signed({4'd0, imu_hdr_pkg::atan_lut(i_cmd.idx)});

    // Rounding of the scaled speed, the heading and the position increment
    assign vk_t    = prod + 65'sd8192;
    assign inc_t   = prod + 65'sd8388608;
    assign hd_t    = r_cz + 34'sd32768;
    assign zr      = {{2{r_hd[15]}}, r_hd, 16'd0};
    assign pos_sum = (i_cmd.op == imu_hdr_pkg::OP_PXA) ?
                     (42'(r_pos_x) + 42'(r_inc)) : (42'(r_pos_y) + 42'(r_inc));

    // Clamp the new position
    always_comb begin
        if (pos_sum > 42'sd549755813887) begin
            pos_sat = 40'sh7F_FFFF_FFFF;
        end else if (pos_sum < -42'sd549755813888) begin
            pos_sat = 40'sh80_0000_0000;
        end else begin
            pos_sat = pos_sum[39:0];
        end
    end

    // Persistent state: reference orientation and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= 1'b0;
            r_q2[0] <= 16'sd16384;
            r_q2[1] <= '0;
            r_q2[2] <= '0;
            r_q2[3] <= '0;
            r_pos_x <= '0;
            r_pos_y <= '0;
        end else begin
            if (i_cmd.op == imu_hdr_pkg::OP_LOAD && !r_taken) begin
                r_taken <= 1'b1;
                r_q2[0] <= i_orient_w;
                r_q2[1] <= i_orient_x;
                r_q2[2] <= i_orient_y;
                r_q2[3] <= i_orient_z;
            end
            if (i_cmd.op == imu_hdr_pkg::OP_PXA) begin
                r_pos_x <= pos_sat;
            end
            if (i_cmd.op == imu_hdr_pkg::OP_PYA) begin
                r_pos_y <= pos_sat;
            end
        end
    end

    // Working registers of one item
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            imu_hdr_pkg::OP_LOAD: begin
                r_v     <= i_wheel_speed;
                r_q1[0] <= i_orient_w;
                r_q1[1] <= i_orient_x;
                r_q1[2] <= i_orient_y;
                r_q1[3] <= i_orient_z;
                r_dt    <= i_time_step;
            end
            imu_hdr_pkg::OP_QMAC: begin
                r_acc <= acc_n;
                if (q_j == 2'd3) begin
                    r_rel[q_c] <= rnd_sat16(acc_n);
                end
            end
            imu_hdr_pkg::OP_NMAC: begin
                r_acc <= acc_n;
                if (i_cmd.idx[2:0] == 3'd3) begin
                    r_den <= acc_n;
                end
                if (i_cmd.idx[2:0] == 3'd5) begin
                    r_num <= acc_n <<< 1;
                end
            end
            imu_hdr_pkg::OP_VPRE: begin
                // Fold the left half plane by a quarter turn
                r_zero <= (r_den == '0) && (r_num == '0);
                if (r_den[35]) begin
                    if (!r_num[35]) begin
                        r_cx <= r_num;
                        r_cy <= -r_den;
                        r_cz <= imu_hdr_pkg::HALF_PI;
                    end else begin
                        r_cx <= -r_num;
                        r_cy <= r_den;
                        r_cz <= -imu_hdr_pkg::HALF_PI;
                    end
                end else begin
                    r_cx <= r_den;
                    r_cy <= r_num;
                    r_cz <= '0;
                end
            end
            imu_hdr_pkg::OP_VIT: begin
                if (!r_cy[35]) begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + atan_v;
                end else begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - atan_v;
                end
            end
            imu_hdr_pkg::OP_VK: begin
                r_vk <= 36'(vk_t >>> 14);
                r_hd <= r_zero ? 16'sd0 : hd_t[31:16];
            end
            imu_hdr_pkg::OP_RPRE: begin
                if (zr > imu_hdr_pkg::HALF_PI) begin
                    r_cx <= '0;
                    r_cy <= r_vk;
                    r_cz <= zr - imu_hdr_pkg::HALF_PI;
                end else if (zr < -imu_hdr_pkg::HALF_PI) begin
                    r_cx <= '0;
                    r_cy <= -r_vk;
                    r_cz <= zr + imu_hdr_pkg::HALF_PI;
                end else begin
                    r_cx <= r_vk;
                    r_cy <= '0;
                    r_cz <= zr;
                end
            end
            imu_hdr_pkg::OP_RIT: begin
                if (!r_cz[33]) begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - atan_v;
                end else begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + atan_v;
                end
            end
            imu_hdr_pkg::OP_PX, imu_hdr_pkg::OP_PY: begin
                r_inc <= 41'(inc_t >>> 24);
            end
            imu_hdr_pkg::OP_OUT: begin
                r_o_pos_x  <= r_pos_x;
                r_o_pos_y  <= r_pos_y;
                r_o_hd     <= r_hd;
                r_o_rel[0] <= r_rel[0];
                r_o_rel[1] <= r_rel[1];
                r_o_rel[2] <= r_rel[2];
                r_o_rel[3] <= r_rel[3];
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_pos_x   = r_o_pos_x;
    assign o_pos_y   = r_o_pos_y;
    assign o_heading = r_o_hd;
    assign o_rel_w   = r_o_rel[0];
    assign o_rel_x   = r_o_rel[1];
    assign o_rel_y   = r_o_rel[2];
    assign o_rel_z   = r_o_rel[3];

endmodule
